// File: rtl/core/char_canvas_shape_rasterizer_top_defines.svh
// assertion macros for the character canvas rasterizer checker
`ifndef CHAR_CANVAS_SHAPE_RASTERIZER_TOP_DEFINES_SVH
`define CHAR_CANVAS_SHAPE_RASTERIZER_TOP_DEFINES_SVH

// consequent checked in the same cycle
`define CCSR_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccsr check failed");

// consequent checked in the cycle after the antecedent
`define CCSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccsr check failed");

`endif

// File: rtl/core/ccsr_pkg.sv
// shared types and constants of the character canvas rasterizer
package ccsr_pkg;

    localparam logic [2:0] MODE_CLEAR  = 3'd0;
    localparam logic [2:0] MODE_POINT  = 3'd1;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_RECT   = 3'd3;
    localparam logic [2:0] MODE_FILL   = 3'd4;
    localparam logic [2:0] MODE_CIRCLE = 3'd5;
    localparam logic [2:0] MODE_DISC   = 3'd6;
    localparam logic [2:0] MODE_READ   = 3'd7;

    localparam logic       CFG_ROWS = 1'b0;
    localparam logic       CFG_COLS = 1'b1;

    localparam logic [6:0] CANVAS_RESET = 7'd64;
    localparam logic [7:0] GLYPH_SPACE  = 8'h20;

    typedef struct packed {
        logic [2:0] mode;
        logic [5:0] p_col;
        logic [5:0] p_row;
        logic [5:0] q_col;
        logic [5:0] q_row;
        logic [6:0] radius;
        logic [7:0] glyph;
    } t_cmd;

    typedef struct packed {
        logic [7:0] read_glyph;
        logic       clipped;
    } t_res;

    typedef struct packed {
        logic [6:0] rows;
        logic [6:0] cols;
    } t_cfg;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_POINT,
        OP_LINE,
        OP_RECT,
        OP_FILL,
        OP_CIRCLE,
        OP_DISC,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op  op;
        t_cmd cmd;
    } t_job;

    typedef struct packed {
        logic        we;
        logic [15:0] addr;
        logic [7:0]  data;
    } t_fb_req;

    typedef enum logic [3:0] {
        SQ_INIT,
        SQ_IDLE,
        SQ_CLEAR,
        SQ_POINT,
        SQ_LINE,
        SQ_RECT,
        SQ_FILL,
        SQ_CSETUP,
        SQ_CIRCLE,
        SQ_READ,
        SQ_RWAIT,
        SQ_DONE
    } t_seq_state;

endpackage

// File: rtl/core/ccsr_fbuf.sv
// character framebuffer memory, one write and one registered read per cycle
module ccsr_fbuf #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              i_clk,
    input  ccsr_pkg::t_fb_req i_req,
    output logic [7:0]        o_rd_data
);
    import ccsr_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr[AW-1:0]] <= i_req.data;
        end
        r_rd_data <= r_mem[i_req.addr[AW-1:0]];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/ccsr_front.sv
// command intake: decodes each item and queues it for the drawing engine
module ccsr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ccsr_pkg::t_cmd i_item,
    input  logic           i_hold,
    output logic           o_job_valid,
    output ccsr_pkg::t_job o_job,
    input  logic           i_job_pop
);
    import ccsr_pkg::*;

    t_job       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       accept;
    t_op        op;

    always_comb begin
        case (i_item.mode)
            MODE_CLEAR:  op = OP_CLEAR;
            MODE_POINT:  op = OP_POINT;
            MODE_LINE:   op = OP_LINE;
            MODE_RECT:   op = OP_RECT;
            MODE_FILL:   op = OP_FILL;
            MODE_CIRCLE: op = OP_CIRCLE;
            MODE_DISC:   op = OP_DISC;
            MODE_READ:   op = OP_READ;
            default:     op = OP_READ;
        endcase
    end

    assign o_stall     = (r_cnt == 2'd2) || i_hold;
    assign accept      = i_valid && !o_stall;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (i_job_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(accept) - 2'(i_job_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= '{op: op, cmd: i_item};
        end
    end

endmodule

// File: rtl/core/ccsr_back.sv
// drawing engine: walks the cells of each command and writes or reads the framebuffer
module ccsr_back #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ccsr_pkg::t_cfg    i_cfg,
    input  logic              i_job_valid,
    input  ccsr_pkg::t_job    i_job,
    output logic              o_job_pop,
    output logic              o_init_busy,
    output ccsr_pkg::t_fb_req o_req,
    input  logic [7:0]        i_rd_data,
    output logic              o_valid,
    input  logic              i_stall,
    output ccsr_pkg::t_res    o_item
);
    import ccsr_pkg::*;

    localparam int             DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int             AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]  LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [8:0]     ROWS_LIM  = 9'(MAX_ROWS);
    localparam logic [8:0]     COLS_LIM  = 9'(MAX_COLS);

    t_seq_state r_state, n_state;
    t_job       r_job, n_job;
    logic [AW-1:0] r_addr, n_addr;
    logic [5:0] r_c0, n_c0, r_r0, n_r0;
    logic signed [8:0] r_e, n_e;
    logic [1:0] r_phase, n_phase;
    logic [5:0] r_k, n_k, r_m, n_m;
    logic [7:0] r_i, n_i, r_j, n_j;
    logic [15:0] r_asq, n_asq, r_bsq, n_bsq, r_ccsq, n_ccsq, r_r2, n_r2;
    logic       r_clip, n_clip;
    logic [7:0] r_rd, n_rd;
    logic       r_out_valid;
    t_res       r_out;

    t_cmd       c;
    logic [8:0] nr, nc;
    logic       out_free;
    logic       d_we, clr_we, in_rng;
    logic [7:0] d_row, d_col;
    logic [15:0] cell_addr;
    logic [5:0] ldc, ldr;
    logic       line_end;
    logic signed [9:0] e2;
    logic       c_step, r_step;
    logic [5:0] rlo, rhi;
    logic       rect_empty, fill_empty;
    logic [15:0] dsum;
    logic [17:0] d4, outer, inner;
    logic       hit, row_last, col_last;
    logic signed [8:0] a_off, b_off;
    logic signed [9:0] a_inc, b_inc;
    logic [5:0] i_dc, i_dr;

    function automatic logic [5:0] f_adiff(input logic [5:0] a, input logic [5:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    assign c        = r_job.cmd;
    assign nr       = ({2'b00, i_cfg.rows} > ROWS_LIM) ? ROWS_LIM : {2'b00, i_cfg.rows};
    assign nc       = ({2'b00, i_cfg.cols} > COLS_LIM) ? COLS_LIM : {2'b00, i_cfg.cols};
    assign out_free = !r_out_valid || !i_stall;

    // line stepping
    assign ldc      = f_adiff(c.q_col, c.p_col);
    assign ldr      = f_adiff(c.q_row, c.p_row);
    assign line_end = (r_c0 == c.q_col) && (r_r0 == c.q_row);
    assign e2       = {r_e, 1'b0};
    assign c_step   = e2 > -$signed({4'b0000, ldr});
    assign r_step   = e2 < $signed({4'b0000, ldc});
    assign i_dc     = f_adiff(i_job.cmd.q_col, i_job.cmd.p_col);
    assign i_dr     = f_adiff(i_job.cmd.q_row, i_job.cmd.p_row);

    // rectangle edges
    assign rlo        = r_phase[1] ? c.p_row : c.p_col;
    assign rhi        = r_phase[1] ? c.q_row : c.q_col;
    assign rect_empty = rlo > rhi;
    assign fill_empty = (c.p_col > c.q_col) || (c.p_row > c.q_row);

    // circle tests
    assign dsum  = r_asq + r_bsq;
    assign d4    = {dsum, 2'b00};
    assign outer = {r_r2, 2'b00} + 18'({c.radius, 2'b00}) + 18'd1;
    assign inner = {r_r2, 2'b00} - 18'({c.radius, 2'b00}) + 18'd1;
    assign hit   = (r_job.op == OP_DISC) ? (dsum <= r_r2) :
                   ((d4 < outer) && ((c.radius == 7'd0) || (d4 > inner)));
    assign row_last = ({1'b0, r_i} == nr - 9'd1);
    assign col_last = ({1'b0, r_j} == nc - 9'd1);
    assign a_off = $signed({1'b0, r_i}) - $signed({3'b000, c.p_row});
    assign b_off = $signed({1'b0, r_j}) - $signed({3'b000, c.p_col});
    assign a_inc = {a_off, 1'b0} + 10'sd1;
    assign b_inc = {b_off, 1'b0} + 10'sd1;

    assign in_rng    = ({1'b0, d_row} < nr) && ({1'b0, d_col} < nc);
    assign cell_addr = 16'(d_row) * 16'(MAX_COLS) + 16'(d_col);

    always_comb begin
        n_state = r_state;
        case (r_state)
            SQ_INIT: begin
                if (r_addr == LAST_ADDR) n_state = SQ_IDLE;
            end
            SQ_IDLE: begin
                if (i_job_valid) begin
                    case (i_job.op)
                        OP_CLEAR:  n_state = SQ_CLEAR;
                        OP_POINT:  n_state = SQ_POINT;
                        OP_LINE:   n_state = SQ_LINE;
                        OP_RECT:   n_state = SQ_RECT;
                        OP_FILL:   n_state = SQ_FILL;
                        OP_CIRCLE: n_state = SQ_CSETUP;
                        OP_DISC:   n_state = SQ_CSETUP;
                        OP_READ:   n_state = SQ_READ;
                        default:   n_state = SQ_DONE;
                    endcase
                end
            end
            SQ_CLEAR: begin
                if (r_addr == LAST_ADDR) n_state = SQ_DONE;
            end
            SQ_POINT:  n_state = SQ_DONE;
            SQ_LINE: begin
                if (line_end) n_state = SQ_DONE;
            end
            SQ_RECT: begin
                if (r_phase == 2'd3 && (rect_empty || r_k == rhi)) n_state = SQ_DONE;
            end
            SQ_FILL: begin
                if (fill_empty || (r_m == c.q_row && r_k == c.q_col)) n_state = SQ_DONE;
            end
            SQ_CSETUP: begin
                n_state = (nr == 9'd0 || nc == 9'd0) ? SQ_DONE : SQ_CIRCLE;
            end
            SQ_CIRCLE: begin
                if (row_last && col_last) n_state = SQ_DONE;
            end
            SQ_READ:   n_state = in_rng ? SQ_RWAIT : SQ_DONE;
            SQ_RWAIT:  n_state = SQ_DONE;
            SQ_DONE: begin
                if (out_free) n_state = SQ_IDLE;
            end
            default:   n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        n_job   = r_job;
        n_addr  = r_addr;
        n_c0    = r_c0;
        n_r0    = r_r0;
        n_e     = r_e;
        n_phase = r_phase;
        n_k     = r_k;
        n_m     = r_m;
        n_i     = r_i;
        n_j     = r_j;
        n_asq   = r_asq;
        n_bsq   = r_bsq;
        n_ccsq  = r_ccsq;
        n_r2    = r_r2;
        n_clip  = r_clip;
        n_rd    = r_rd;
        d_we    = 1'b0;
        d_row   = 8'd0;
        d_col   = 8'd0;
        clr_we  = 1'b0;
        o_job_pop = 1'b0;
        case (r_state)
            SQ_INIT, SQ_CLEAR: begin
                clr_we = 1'b1;
                n_addr = (r_addr == LAST_ADDR) ? '0 : r_addr + AW'(1);
            end
            SQ_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job   = i_job;
                    n_clip  = 1'b0;
                    n_rd    = 8'd0;
                    n_addr  = '0;
                    n_c0    = i_job.cmd.p_col;
                    n_r0    = i_job.cmd.p_row;
                    n_e     = $signed({3'b000, i_dc}) - $signed({3'b000, i_dr});
                    n_phase = 2'd0;
                    n_k     = i_job.cmd.p_col;
                    n_m     = i_job.cmd.p_row;
                end
            end
            SQ_POINT: begin
                d_we  = 1'b1;
                d_row = 8'(c.p_row);
                d_col = 8'(c.q_col);
            end
            SQ_LINE: begin
                d_we  = 1'b1;
                d_row = 8'(r_r0);
                d_col = 8'(r_c0);
                if (!line_end) begin
                    n_e = r_e - (c_step ? $signed({3'b000, ldr}) : 9'sd0)
                              + (r_step ? $signed({3'b000, ldc}) : 9'sd0);
                    if (c_step) n_c0 = (c.p_col < c.q_col) ? r_c0 + 6'd1 : r_c0 - 6'd1;
                    if (r_step) n_r0 = (c.p_row < c.q_row) ? r_r0 + 6'd1 : r_r0 - 6'd1;
                end
            end
            SQ_RECT: begin
                if (!rect_empty) begin
                    d_we = 1'b1;
                    case (r_phase)
                        2'd0: begin d_row = 8'(c.p_row); d_col = 8'(r_k);   end
                        2'd1: begin d_row = 8'(c.q_row); d_col = 8'(r_k);   end
                        2'd2: begin d_row = 8'(r_k);     d_col = 8'(c.p_col); end
                        default: begin d_row = 8'(r_k);  d_col = 8'(c.q_col); end
                    endcase
                end
                if (rect_empty || r_k == rhi) begin
                    n_phase = r_phase + 2'd1;
                    n_k     = (r_phase == 2'd0) ? c.p_col : c.p_row;
                end else begin
                    n_k = r_k + 6'd1;
                end
            end
            SQ_FILL: begin
                if (!fill_empty) begin
                    d_we  = 1'b1;
                    d_row = 8'(r_m);
                    d_col = 8'(r_k);
                    if (r_m == c.q_row) begin
                        n_m = c.p_row;
                        n_k = r_k + 6'd1;
                    end else begin
                        n_m = r_m + 6'd1;
                    end
                end
            end
            SQ_CSETUP: begin
                n_asq  = 16'({10'd0, c.p_row} * {10'd0, c.p_row});
                n_bsq  = 16'({10'd0, c.p_col} * {10'd0, c.p_col});
                n_ccsq = 16'({10'd0, c.p_col} * {10'd0, c.p_col});
                n_r2   = 16'({9'd0, c.radius} * {9'd0, c.radius});
                n_i    = 8'd0;
                n_j    = 8'd0;
            end
            SQ_CIRCLE: begin
                d_we  = hit;
                d_row = r_i;
                d_col = r_j;
                if (col_last) begin
                    n_j   = 8'd0;
                    n_i   = r_i + 8'd1;
                    n_bsq = r_ccsq;
                    n_asq = 16'($signed({2'b00, r_asq}) + {{8{a_inc[9]}}, a_inc});
                end else begin
                    n_j   = r_j + 8'd1;
                    n_bsq = 16'($signed({2'b00, r_bsq}) + {{8{b_inc[9]}}, b_inc});
                end
            end
            SQ_READ: begin
                d_row = 8'(c.p_row);
                d_col = 8'(c.q_col);
                if (!in_rng) n_clip = 1'b1;
            end
            SQ_RWAIT: begin
                n_rd = i_rd_data;
            end
            default: begin
            end
        endcase
        if (d_we && !in_rng) n_clip = 1'b1;
    end

    always_comb begin
        o_req.we   = clr_we || (d_we && in_rng);
        o_req.addr = clr_we ? 16'(r_addr) : cell_addr;
        o_req.data = clr_we ? GLYPH_SPACE : c.glyph;
    end

    assign o_init_busy = (r_state == SQ_INIT);
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SQ_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (r_state == SQ_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_job   <= n_job;
        r_c0    <= n_c0;
        r_r0    <= n_r0;
        r_e     <= n_e;
        r_phase <= n_phase;
        r_k     <= n_k;
        r_m     <= n_m;
        r_i     <= n_i;
        r_j     <= n_j;
        r_asq   <= n_asq;
        r_bsq   <= n_bsq;
        r_ccsq  <= n_ccsq;
        r_r2    <= n_r2;
        r_clip  <= n_clip;
        r_rd    <= n_rd;
        if (r_state == SQ_DONE && out_free) begin
            r_out <= '{read_glyph: r_rd, clipped: r_clip};
        end
    end

endmodule

// File: rtl/core/char_canvas_shape_rasterizer_top.sv
// top level of the character canvas shape rasterizer
// Commands are queued two deep and carried out one at a time, one framebuffer cell
// per cycle while a command walks its cells; a finished command waits until the
// result output has room. Point and read visit one cell, a line each plotted cell,
// a rectangle outline its perimeter, a filled rectangle its area, circles a setup
// step plus rows-in-use times columns-in-use cells, and clear all MAX_ROWS*MAX_COLS
// cells. The single-port framebuffer walk sets this rate.
// After reset the framebuffer is swept to spaces, during which o_stall stays high;
// configuration writes are taken at any time.
module char_canvas_shape_rasterizer_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  ccsr_pkg::t_cmd i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output ccsr_pkg::t_res o_item,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [6:0]     i_cfg_data
);
    import ccsr_pkg::*;

    t_cfg    r_cfg;
    logic    job_valid, job_pop, init_busy;
    t_job    job;
    t_fb_req req;
    logic [7:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{rows: CANVAS_RESET, cols: CANVAS_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: r_cfg.rows <= i_cfg_data;
                CFG_COLS: r_cfg.cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ccsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .i_hold      (init_busy),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    ccsr_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_init_busy (init_busy),
        .o_req       (req),
        .i_rd_data   (rd_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_item      (o_item)
    );

    ccsr_fbuf #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_fbuf (
        .i_clk     (i_clk),
        .i_req     (req),
        .o_rd_data (rd_data)
    );

endmodule

// File: rtl/core/ccsr_checker.sv
// port-level checks of the character canvas rasterizer, bound to the top level
`include "char_canvas_shape_rasterizer_top_defines.svh"

module ccsr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_stall,
    input logic           o_valid,
    input logic           i_stall,
    input ccsr_pkg::t_res o_item
);
    import ccsr_pkg::*;

    `CCSR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `CCSR_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && i_stall, $stable(o_item))
    `CCSR_ASSERT_SAME(a_clip_no_glyph, i_clk, i_rst_n, o_valid && o_item.clipped, o_item.read_glyph == 8'h00)
    `CCSR_ASSERT_SAME(a_reset_sweep, i_clk, i_rst_n, $past(!i_rst_n), o_stall && !o_valid)

endmodule

bind char_canvas_shape_rasterizer_top ccsr_checker u_ccsr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_item  (o_item)
);

// File: test/char_canvas_shape_rasterizer_tb.sv
// testbench of the character canvas shape rasterizer: predicts each command result and checks it
`timescale 1ns / 1ps

class canvas_scoreboard;
    logic [7:0] cells [0:4095];
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    ccsr_pkg::t_res pending [$];
    int errors;
    bit hit_clip;

    function new();
        foreach (cells[i]) cells[i] = ccsr_pkg::GLYPH_SPACE;
        rows_cfg = 32'(ccsr_pkg::CANVAS_RESET);
        cols_cfg = 32'(ccsr_pkg::CANVAS_RESET);
        errors = 0;
    endfunction

    function int unsigned rows_in_use();
        return rows_cfg > 64 ? 64 : rows_cfg;
    endfunction

    function int unsigned cols_in_use();
        return cols_cfg > 64 ? 64 : cols_cfg;
    endfunction

    function void plot(int r, int c, logic [7:0] g);
        if (r < 0 || c < 0 || r >= int'(rows_in_use()) || c >= int'(cols_in_use())) begin
            hit_clip = 1;
        end else begin
            cells[r * 64 + c] = g;
        end
    endfunction

    function void note_command(ccsr_pkg::t_cmd cmd);
        ccsr_pkg::t_res res;
        int pc, pr, qc, qr, rad, dc, dr, sc, sr, e, e2, a, b, d, outer, inner;
        bit on;
        pc = int'(cmd.p_col); pr = int'(cmd.p_row);
        qc = int'(cmd.q_col); qr = int'(cmd.q_row); rad = int'(cmd.radius);
        hit_clip = 0;
        res.read_glyph = 8'h00;
        case (cmd.mode)
            ccsr_pkg::MODE_CLEAR: begin
                foreach (cells[i]) cells[i] = ccsr_pkg::GLYPH_SPACE;
            end
            ccsr_pkg::MODE_POINT: plot(pr, qc, cmd.glyph);
            ccsr_pkg::MODE_LINE: begin
                dc = qc > pc ? qc - pc : pc - qc;
                dr = qr > pr ? qr - pr : pr - qr;
                sc = pc < qc ? 1 : -1;
                sr = pr < qr ? 1 : -1;
                e = dc - dr;
                while (pc != qc || pr != qr) begin
                    e2 = 2 * e;
                    plot(pr, pc, cmd.glyph);
                    if (e2 > -dr) begin
                        e -= dr;
                        pc += sc;
                    end
                    if (e2 < dc) begin
                        e += dc;
                        pr += sr;
                    end
                end
                plot(qr, qc, cmd.glyph);
            end
            ccsr_pkg::MODE_RECT: begin
                for (int k = pc; k <= qc; k++) plot(pr, k, cmd.glyph);
                for (int k = pc; k <= qc; k++) plot(qr, k, cmd.glyph);
                for (int k = pr; k <= qr; k++) plot(k, pc, cmd.glyph);
                for (int k = pr; k <= qr; k++) plot(k, qc, cmd.glyph);
            end
            ccsr_pkg::MODE_FILL: begin
                for (int k = pc; k <= qc; k++)
                    for (int m = pr; m <= qr; m++) plot(m, k, cmd.glyph);
            end
            ccsr_pkg::MODE_CIRCLE, ccsr_pkg::MODE_DISC: begin
                outer = (2 * rad + 1) * (2 * rad + 1);
                inner = (2 * rad - 1) * (2 * rad - 1);
                for (int i = 0; i < int'(rows_in_use()); i++) begin
                    for (int j = 0; j < int'(cols_in_use()); j++) begin
                        a = i - pr;
                        b = j - pc;
                        d = a * a + b * b;
                        if (cmd.mode == ccsr_pkg::MODE_DISC) on = d <= rad * rad;
                        else on = (4 * d < outer) && (rad == 0 || 4 * d > inner);
                        if (on) cells[i * 64 + j] = cmd.glyph;
                    end
                end
            end
            default: begin
                if (pr < int'(rows_in_use()) && qc < int'(cols_in_use()))
                    res.read_glyph = cells[pr * 64 + qc];
                else
                    hit_clip = 1;
            end
        endcase
        res.clipped = hit_clip;
        pending.push_back(res);
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check_result(ccsr_pkg::t_res got);
        ccsr_pkg::t_res want;
        if (pending.size() == 0) begin
            report("unexpected item", 1, 0);
            return;
        end
        want = pending.pop_front();
        if (got.read_glyph !== want.read_glyph)
            report("read_glyph", int'(got.read_glyph), int'(want.read_glyph));
        if (got.clipped !== want.clipped)
            report("clipped", int'(got.clipped), int'(want.clipped));
    endtask
endclass

module testbench;
    import ccsr_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    t_cmd i_item = '0;
    logic o_valid;
    logic i_stall = 0;
    t_res o_item;
    logic i_cfg_we = 0;
    logic i_cfg_idx = CFG_ROWS;
    logic [6:0] i_cfg_data = '0;

    canvas_scoreboard board = new();
    int cycles = 0;
    bit calm = 0;
    bit hold_off = 0;
    int idle_left = 0;

    char_canvas_shape_rasterizer_top DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_item);
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (hold_off) begin
            i_stall <= 1;
        end else if (idle_left > 0) begin
            idle_left--;
            i_stall <= 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(0, 12);
            i_stall <= 1;
        end else begin
            i_stall <= 0;
        end
    end

    // valid stays high between items; callers that pause drop it first
    task automatic send(t_cmd cmd);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_item <= cmd;
        i_valid <= 1;
        do @(posedge i_clk); while (o_stall);
        board.note_command(cmd);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [6:0] value);
        drain();
        repeat (20) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_ROWS) board.rows_cfg = 32'(value);
        else board.cols_cfg = 32'(value);
    endtask

    function automatic t_cmd rand_cmd(logic [2:0] m);
        t_cmd c;
        c.mode = m;
        c.p_col = 6'($urandom);
        c.p_row = 6'($urandom);
        c.q_col = 6'($urandom);
        c.q_row = 6'($urandom);
        c.radius = $urandom_range(0, 3) == 0 ? 7'($urandom) : 7'($urandom_range(0, 12));
        c.glyph = 8'($urandom);
        return c;
    endfunction

    function automatic t_cmd mk(logic [2:0] m, int pc, int pr, int qc, int qr, int rad, int g);
        t_cmd c;
        c.mode = m; c.p_col = 6'(pc); c.p_row = 6'(pr); c.q_col = 6'(qc); c.q_row = 6'(qr);
        c.radius = 7'(rad); c.glyph = 8'(g);
        return c;
    endfunction

    task automatic random_run(int n);
        logic [2:0] m;
        for (int i = 0; i < n; i++) begin
            // mostly drawing commands and reads, with an occasional clear
            m = $urandom_range(0, 19) == 0 ? MODE_CLEAR : 3'($urandom_range(1, 7));
            send(rand_cmd(m));
        end
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        send(mk(MODE_POINT, 0, 0, 0, 0, 0, 8'hFF));
        send(mk(MODE_POINT, 0, 63, 63, 0, 0, 8'h00));
        send(mk(MODE_READ, 0, 0, 0, 0, 0, 0));
        send(mk(MODE_READ, 0, 63, 63, 0, 0, 0));
        send(mk(MODE_LINE, 0, 0, 63, 63, 0, 8'h41));
        send(mk(MODE_LINE, 60, 5, 3, 40, 0, 8'h42));
        send(mk(MODE_LINE, 7, 7, 7, 7, 0, 8'h43));
        send(mk(MODE_RECT, 2, 3, 20, 10, 0, 8'h44));
        send(mk(MODE_RECT, 20, 3, 2, 10, 0, 8'h45));
        send(mk(MODE_RECT, 2, 10, 20, 3, 0, 8'h46));
        send(mk(MODE_FILL, 30, 30, 40, 35, 0, 8'h47));
        send(mk(MODE_FILL, 40, 30, 30, 35, 0, 8'h48));
        send(mk(MODE_CIRCLE, 32, 32, 10, 0, 0, 8'h49));
        send(mk(MODE_CIRCLE, 5, 5, 0, 0, 0, 8'h4A));
        send(mk(MODE_DISC, 50, 50, 127, 0, 127, 8'h4B));
        send(mk(MODE_CIRCLE, 0, 0, 0, 0, 127, 8'h4C));
        send(mk(MODE_READ, 0, 32, 32, 0, 0, 0));
        send(mk(MODE_CLEAR, 63, 63, 63, 63, 127, 8'hFF));
        send(mk(MODE_READ, 0, 10, 10, 0, 0, 0));
        random_run(35);

        write_reg(CFG_ROWS, 7'd1);
        write_reg(CFG_COLS, 7'd127);
        send(mk(MODE_LINE, 0, 0, 63, 5, 0, 8'h50));
        send(mk(MODE_READ, 0, 1, 3, 0, 0, 0));
        random_run(15);

        write_reg(CFG_ROWS, 7'd0);
        write_reg(CFG_COLS, 7'd0);
        send(mk(MODE_POINT, 0, 0, 0, 0, 0, 8'h51));
        send(mk(MODE_DISC, 0, 0, 0, 0, 5, 8'h52));
        send(mk(MODE_READ, 0, 0, 0, 0, 0, 0));

        write_reg(CFG_ROWS, 7'd20);
        write_reg(CFG_COLS, 7'd13);
        random_run(20);

        // long receiver hold-off while the sender keeps going
        hold_off = 1;
        fork
            begin
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end
            random_run(6);
        join

        write_reg(CFG_ROWS, 7'd64);
        write_reg(CFG_COLS, 7'd64);
        random_run(25);
        calm = 1;
        random_run(15);

        drain();
        repeat (5000) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ccsr_pkg.sv
rtl/core/ccsr_fbuf.sv
rtl/core/ccsr_front.sv
rtl/core/ccsr_back.sv
rtl/core/char_canvas_shape_rasterizer_top.sv
rtl/core/ccsr_checker.sv
test/char_canvas_shape_rasterizer_tb.sv
